// ----- sv/ssed_pkg.sv -----
// Shared types and constants of the spring energy derivative pipeline.
`default_nettype none
package ssed_pkg;

  // Quotient bits produced by each divider.
  localparam int QW = 64;

  // Register stages in one divider: the overflow check, then one per quotient bit.
  localparam int DIV_LAT = QW + 1;

  // Per-element side information that travels with the data.
  typedef struct packed {
    logic [19:0] id;
    logic        ff;
    logic        fs;
    logic        both_fixed;
    logic        zero_len;
    logic        d_neg;
    logic        dm_neg;
    logic        hm_neg;
  } side_t;

endpackage
`default_nettype wire

// ----- sv/ssed_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, with an overflow flag.
`default_nettype none
module ssed_div #(
  parameter int NW = 168,
  parameter int DW = 107
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [NW-1:0]          num,
  input  wire logic [DW-1:0]          den,
  output logic      [ssed_pkg::QW-1:0] quo,
  output logic                        ovf
);

  localparam int QW = ssed_pkg::QW;
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_q [0:QW];
  logic [DW-1:0] den_q [0:QW];
  logic [QW-1:0] quo_q [0:QW];
  logic          ovf_q [0:QW];

  // Flag quotients that do not fit in QW bits; the bit stages then need
  // only compare against the shifted divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= CW'(num);
      den_q[0] <= den;
      quo_q[0] <= '0;
      ovf_q[0] <= CW'(num) >= (CW'(den) << QW);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    localparam int B = QW - k;
    logic [CW-1:0] dsh;
    logic          ge;
    logic [QW-1:0] qn;

    always_comb begin
      dsh   = CW'(den_q[k-1]) << B;
      ge    = rem_q[k-1] >= dsh;
      qn    = quo_q[k-1];
      qn[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? rem_q[k-1] - dsh : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= qn;
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo = quo_q[QW];
  assign ovf = ovf_q[QW];

endmodule
`default_nettype wire

// ----- sv/stvk_spring_energy_derivs.sv -----
// Top level: St. Venant-Kirchhoff spring energy, gradient and Hessian pipeline.
//
//  Channel | Direction | Signals                 | Contents
//  --------+-----------+-------------------------+---------------------------------
//  s       | in        | s_tvalid/tready/tdata   | one element per transfer
//  m       | out       | m_tvalid/tready/tdata   | one result per element
//
// One element enters every cycle while the output is not stalled; results leave in order
// through 7 arithmetic stages, 65 divider stages and one saturation/output stage.
// The three 64-bit restoring dividers, one quotient bit per stage, set the depth.
// rst clears all valid bits; payload registers hold no reset.
// The whole pipeline advances together: a stalled output holds every stage,
// so nothing is dropped or repeated.
`default_nettype none
module stvk_spring_energy_derivs #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // element_id[19:0], rest_first[51:20], rest_second[83:52], cur_first[115:84],
  // cur_second[147:116], free_first[148], free_second[149],
  // youngs_modulus[181:150], zero pad [183:182]
  input  wire logic [183:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // id_out[19:0], energy[83:20], grad_first[147:84], grad_second[211:148],
  // hess_aa[275:212], hess_ab[339:276], hess_bb[403:340], degenerate[404],
  // zero pad [407:405]
  output logic      [407:0] m_tdata
);

  localparam int QW      = ssed_pkg::QW;
  localparam int DIV_LAT = ssed_pkg::DIV_LAT;
  localparam int NSH     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int DSH     = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int NWE     = 160 + NSH;
  localparam int DWE     = 99 + DSH;
  localparam int NWG     = 128 + NSH;
  localparam int DWG     = 97 + DSH;
  localparam int NWH     = 98 + NSH;

  logic en;
  logic [6:0]         vld_s;
  logic [DIV_LAT-1:0] vld_d;
  logic               out_vld;

  ssed_pkg::side_t side_s [0:6];
  ssed_pkg::side_t side_d [0:DIV_LAT-1];

  // Advance everything when the output register is empty or being taken.
  assign en       = !out_vld || m_tready;
  assign s_tready = en;
  assign m_tvalid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s   <= '0;
      vld_d   <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld_s   <= {vld_s[5:0], s_tvalid};
      vld_d   <= {vld_d[DIV_LAT-2:0], vld_s[6]};
      out_vld <= vld_d[DIV_LAT-1];
    end
  end

  // Stage 1: lengths, magnitudes and flags.
  logic signed [31:0] rf, rs, cf, cs;
  logic               ff_in, fs_in;
  logic signed [32:0] len_w, d_w, p1_w, p2_w;
  logic        [32:0] len_mag, d_mag;
  logic        [31:0] ad1, al1, y1;

  always_comb begin
    rf      = s_tdata[51:20];
    rs      = s_tdata[83:52];
    cf      = s_tdata[115:84];
    cs      = s_tdata[147:116];
    ff_in   = s_tdata[148];
    fs_in   = s_tdata[149];
    p1_w    = ff_in ? 33'(cf) : 33'(rf);
    p2_w    = fs_in ? 33'(cs) : 33'(rs);
    len_w   = 33'(rs) - 33'(rf);
    d_w     = p2_w - p1_w;
    len_mag = len_w[32] ? 33'(-len_w) : 33'(len_w);
    d_mag   = d_w[32] ? 33'(-d_w) : 33'(d_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad1                  <= d_mag[31:0];
      al1                  <= len_mag[31:0];
      y1                   <= s_tdata[181:150];
      side_s[0].id         <= s_tdata[19:0];
      side_s[0].ff         <= ff_in;
      side_s[0].fs         <= fs_in;
      side_s[0].both_fixed <= !ff_in && !fs_in;
      side_s[0].zero_len   <= len_w == 33'sd0;
      side_s[0].d_neg      <= d_w[32];
      side_s[0].dm_neg     <= 1'b0;
      side_s[0].hm_neg     <= 1'b0;
    end
  end

  // Stage 2: squares.
  logic [63:0] d2_2, l2_2;
  logic [31:0] al2, ad2, y2;
  always_ff @(posedge clk) begin
    if (en) begin
      d2_2      <= 64'(ad1) * 64'(ad1);
      l2_2      <= 64'(al1) * 64'(al1);
      al2       <= al1;
      ad2       <= ad1;
      y2        <= y1;
      side_s[1] <= side_s[0];
    end
  end

  // Stage 3: |d^2 - L^2|, 3 d^2, partial products of L^3.
  logic            dneg3;
  logic [63:0]     dm3, la3, lb3, l23;
  logic [65:0]     t3;
  logic [31:0]     ad3, y3;
  ssed_pkg::side_t side3_w;
  assign dneg3 = d2_2 < l2_2;
  always_comb begin
    side3_w        = side_s[1];
    side3_w.dm_neg = dneg3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dm3       <= dneg3 ? l2_2 - d2_2 : d2_2 - l2_2;
      la3       <= 64'(l2_2[31:0]) * 64'(al2);
      lb3       <= 64'(l2_2[63:32]) * 64'(al2);
      t3        <= 66'(d2_2) + {1'b0, d2_2, 1'b0};
      l23       <= l2_2;
      ad3       <= ad2;
      y3        <= y2;
      side_s[2] <= side3_w;
    end
  end

  // Stage 4: L^3, |3 d^2 - L^2|, Y * dm and Y * |d| partials.
  logic            hneg4;
  logic [95:0]     l3_4;
  logic [65:0]     hm4;
  logic [63:0]     ya4, yb4, yad4, dm4;
  logic [31:0]     y4;
  ssed_pkg::side_t side4_w;
  assign hneg4 = t3 < 66'(l23);
  always_comb begin
    side4_w        = side_s[2];
    side4_w.hm_neg = hneg4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l3_4      <= 96'(la3) + {lb3, 32'b0};
      hm4       <= hneg4 ? 66'(l23) - t3 : t3 - 66'(l23);
      ya4       <= 64'(y3) * 64'(dm3[31:0]);
      yb4       <= 64'(y3) * 64'(dm3[63:32]);
      yad4      <= 64'(y3) * 64'(ad3);
      dm4       <= dm3;
      y4        <= y3;
      side_s[3] <= side4_w;
    end
  end

  // Stage 5: Y * dm, Hessian and gradient partials.
  logic [95:0] yd5, l3_5;
  logic [63:0] yh5_0, yh5_1, g00, g01, g10, g11, dm5;
  logic [33:0] yh5_2;
  always_ff @(posedge clk) begin
    if (en) begin
      yd5       <= 96'(ya4) + {yb4, 32'b0};
      yh5_0     <= 64'(y4) * 64'(hm4[31:0]);
      yh5_1     <= 64'(y4) * 64'(hm4[63:32]);
      yh5_2     <= 34'(y4) * 34'(hm4[65:64]);
      g00       <= 64'(yad4[31:0]) * 64'(dm4[31:0]);
      g01       <= 64'(yad4[31:0]) * 64'(dm4[63:32]);
      g10       <= 64'(yad4[63:32]) * 64'(dm4[31:0]);
      g11       <= 64'(yad4[63:32]) * 64'(dm4[63:32]);
      dm5       <= dm4;
      l3_5      <= l3_4;
      side_s[4] <= side_s[3];
    end
  end

  // Stage 6: Hessian and gradient numerators, energy partials.
  logic [97:0]  yh6;
  logic [127:0] g6;
  logic [63:0]  e00, e01, e10, e11, e20, e21;
  logic [95:0]  l3_6;
  always_ff @(posedge clk) begin
    if (en) begin
      yh6       <= 98'(yh5_0) + 98'({yh5_1, 32'b0}) + {yh5_2, 64'b0};
      g6        <= 128'(g00) + 128'({g01, 32'b0}) + 128'({g10, 32'b0}) + {g11, 64'b0};
      e00       <= 64'(yd5[31:0]) * 64'(dm5[31:0]);
      e01       <= 64'(yd5[31:0]) * 64'(dm5[63:32]);
      e10       <= 64'(yd5[63:32]) * 64'(dm5[31:0]);
      e11       <= 64'(yd5[63:32]) * 64'(dm5[63:32]);
      e20       <= 64'(yd5[95:64]) * 64'(dm5[31:0]);
      e21       <= 64'(yd5[95:64]) * 64'(dm5[63:32]);
      l3_6      <= l3_5;
      side_s[5] <= side_s[4];
    end
  end

  // Stage 7: energy numerator.
  logic [159:0] e7;
  logic [127:0] g7;
  logic [97:0]  yh7;
  logic [95:0]  l3_7;
  always_ff @(posedge clk) begin
    if (en) begin
      e7        <= 160'(e00) + 160'({e01, 32'b0}) + 160'({e10, 32'b0})
                 + 160'({e11, 64'b0}) + 160'({e20, 64'b0}) + {e21, 96'b0};
      g7        <= g6;
      yh7       <= yh6;
      l3_7      <= l3_6;
      side_s[6] <= side_s[5];
    end
  end

  // Dividers: energy over 8 L^3, gradient and Hessian over 2 L^3.
  logic [QW-1:0] q_e, q_g, q_h;
  logic          o_e, o_g, o_h;

  ssed_div #(.NW(NWE), .DW(DWE)) u_div_e (
    .clk (clk), .en (en),
    .num (NWE'(e7) << NSH), .den (DWE'(l3_7) << (DSH + 3)),
    .quo (q_e), .ovf (o_e)
  );

  ssed_div #(.NW(NWG), .DW(DWG)) u_div_g (
    .clk (clk), .en (en),
    .num (NWG'(g7) << NSH), .den (DWG'(l3_7) << (DSH + 1)),
    .quo (q_g), .ovf (o_g)
  );

  ssed_div #(.NW(NWH), .DW(DWG)) u_div_h (
    .clk (clk), .en (en),
    .num (NWH'(yh7) << NSH), .den (DWG'(l3_7) << (DSH + 1)),
    .quo (q_h), .ovf (o_h)
  );

  // Hold side information alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_s[6];
      for (int i = 1; i < DIV_LAT; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  function automatic logic [63:0] sat64(input logic [63:0] q, input logic o, input logic neg);
    logic [63:0] r;
    if (neg) begin
      r = (o || q > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : 64'(-q);
    end else begin
      r = (o || q[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q;
    end
    return r;
  endfunction

  // Output stage: sign, saturate, zero the rows of fixed endpoints.
  ssed_pkg::side_t sf;
  logic            act, gneg;
  logic [63:0]     e_v, gp_v, gn_v, hp_v, hn_v;

  always_comb begin
    sf   = side_d[DIV_LAT-1];
    act  = !sf.both_fixed && !sf.zero_len;
    gneg = sf.d_neg ^ sf.dm_neg;
    e_v  = sat64(q_e, o_e, 1'b0);
    gp_v = sat64(q_g, o_g, !gneg);
    gn_v = sat64(q_g, o_g, gneg);
    hp_v = sat64(q_h, o_h, sf.hm_neg);
    hn_v = sat64(q_h, o_h, !sf.hm_neg);
  end

  logic [19:0] id_o;
  logic [63:0] en_o, gf_o, gs_o, haa_o, hab_o, hbb_o;
  logic        deg_o;

  always_ff @(posedge clk) begin
    if (en) begin
      id_o  <= sf.id;
      en_o  <= act ? e_v : '0;
      gf_o  <= (act && sf.ff) ? gp_v : '0;
      gs_o  <= (act && sf.fs) ? gn_v : '0;
      haa_o <= (act && sf.ff) ? hp_v : '0;
      hab_o <= (act && sf.ff && sf.fs) ? hn_v : '0;
      hbb_o <= (act && sf.fs) ? hp_v : '0;
      deg_o <= !sf.both_fixed && sf.zero_len;
    end
  end

  assign m_tdata = {3'b000, deg_o, hbb_o, hab_o, haa_o, gs_o, gf_o, en_o, id_o};

  // A degenerate element carries no energy or gradient.
  a_deg_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[404] |-> m_tdata[83:20] == 64'd0 && m_tdata[147:84] == 64'd0
      && m_tdata[211:148] == 64'd0)
    else $error("degenerate result with nonzero outputs");

  // A coupling term exists only when both diagonal terms do.
  a_hab_diag : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[339:276] != 64'd0 |-> m_tdata[275:212] != 64'd0
      && m_tdata[403:340] != 64'd0)
    else $error("hess_ab set without both diagonal entries");

  // Both diagonal entries come from the same quotient.
  a_diag_eq : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[275:212] != 64'd0 && m_tdata[403:340] != 64'd0
      |-> m_tdata[275:212] == m_tdata[403:340])
    else $error("hess_aa and hess_bb differ");

endmodule
`default_nettype wire
